// ===== design/bts_pkg.sv =====
`timescale 1ns / 1ps
package bts_pkg;

    localparam int ID_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0] ZERO_MARK   = 8'ha5;
    localparam logic [7:0] ONE_MARK    = 8'h5a;
    localparam logic [6:0] NONE_BRANCH = 7'h7f;

    localparam logic [1:0] KIND_RESTART = 2'd0;
    localparam logic [1:0] KIND_BEGIN   = 2'd1;
    localparam logic [1:0] KIND_BIT     = 2'd2;

    typedef enum logic [1:0] {
        OP_RESTART,
        OP_BEGIN,
        OP_BIT
    } op_t;

    typedef enum logic [2:0] {
        ST_BIT_SENT,
        ST_ABORT,
        ST_NO_MORE,
        ST_FOUND,
        ST_PASS_STARTED
    } status_t;

    typedef struct packed {
        op_t  op;
        logic has_zero;
        logic has_one;
    } cmd_t;

endpackage

// ===== design/bts_queue.sv =====
`timescale 1ns / 1ps
module bts_queue #(
    parameter int DEPTH = bts_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  bts_pkg::cmd_t in_cmd,
    output logic          in_ready,
    output logic          out_valid,
    output bts_pkg::cmd_t out_cmd,
    input  logic          out_pop
);
    import bts_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t           slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           push;

    assign in_ready  = (cnt_reg != CW'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (out_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !out_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && out_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== design/bts_front.sv =====
`timescale 1ns / 1ps
module bts_front (
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_kind,
    input  logic [7:0]    s_zero_reply,
    input  logic [7:0]    s_one_reply,
    output logic          q_push,
    output bts_pkg::cmd_t q_cmd,
    input  logic          q_ready
);
    import bts_pkg::*;

    logic known;

    assign s_ready = q_ready;

    always_comb begin
        known          = 1'b1;
        q_cmd.op       = OP_RESTART;
        q_cmd.has_zero = (s_zero_reply == ZERO_MARK);
        q_cmd.has_one  = (s_one_reply == ONE_MARK);
        case (s_kind)
            KIND_RESTART: begin
                q_cmd.op = OP_RESTART;
            end
            KIND_BEGIN: begin
                q_cmd.op = OP_BEGIN;
            end
            KIND_BIT: begin
                q_cmd.op = OP_BIT;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // meaningless kinds are taken and dropped
    assign q_push = s_valid && known;

endmodule

// ===== design/bts_back.sv =====
`timescale 1ns / 1ps
module bts_back #(
    parameter int ID_BYTES = bts_pkg::ID_BYTES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  bts_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_status,
    output logic [7:0]    m_direction_byte,
    output logic          m_chosen_bit,
    output logic [5:0]    m_bit_position,
    output logic [63:0]   m_found_id,
    output logic          m_enumeration_done
);
    import bts_pkg::*;

    localparam int ID_BITS = ID_BYTES * 8;
    localparam int IDW     = $clog2(ID_BITS);
    localparam logic [5:0] LAST_POS = 6'(ID_BITS - 1);

    logic [ID_BITS-1:0] id_reg, id_next;
    logic [6:0]         new_zb_reg, new_zb_next;
    logic [6:0]         prior_zb_reg, prior_zb_next;
    logic [5:0]         bit_cnt_reg, bit_cnt_next;
    logic               last_found_reg, last_found_next;

    logic               m_valid_reg, m_valid_next;
    status_t            status_reg, status_next;
    logic [7:0]         dir_reg, dir_next;
    logic               chosen_reg, chosen_next;
    logic [5:0]         pos_reg, pos_next;
    logic [63:0]        found_reg, found_next;
    logic               done_reg, done_next;

    logic               out_free;
    logic [5:0]         shift;
    logic               take_one;
    logic               done;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = q_valid && out_free;
    assign shift    = LAST_POS - bit_cnt_reg;

    always_comb begin
        id_next         = id_reg;
        new_zb_next     = new_zb_reg;
        prior_zb_next   = prior_zb_reg;
        bit_cnt_next    = bit_cnt_reg;
        last_found_next = last_found_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        status_next     = status_reg;
        dir_next        = dir_reg;
        chosen_next     = chosen_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;
        done_next       = done_reg;
        take_one        = q_cmd.has_one;
        done            = 1'b0;

        if (q_valid && q_cmd.has_zero && q_cmd.has_one) begin
            if (!prior_zb_reg[6] && bit_cnt_reg == prior_zb_reg[5:0]) begin
                take_one = 1'b1;
            end else if (!prior_zb_reg[6] && bit_cnt_reg < prior_zb_reg[5:0]) begin
                take_one = id_reg[shift[IDW-1:0]];
            end else begin
                take_one = 1'b0;
            end
        end

        if (q_pop) begin
            dir_next    = '0;
            chosen_next = 1'b0;
            pos_next    = '0;
            found_next  = '0;
            done_next   = 1'b0;
            case (q_cmd.op)
                OP_RESTART: begin
                    id_next         = '0;
                    new_zb_next     = NONE_BRANCH;
                    prior_zb_next   = NONE_BRANCH;
                    bit_cnt_next    = '0;
                    last_found_next = 1'b0;
                end
                OP_BEGIN: begin
                    m_valid_next = 1'b1;
                    if (last_found_reg) begin
                        status_next = ST_NO_MORE;
                    end else begin
                        prior_zb_next = new_zb_reg;
                        new_zb_next   = NONE_BRANCH;
                        bit_cnt_next  = '0;
                        status_next   = ST_PASS_STARTED;
                    end
                end
                OP_BIT: begin
                    m_valid_next = 1'b1;
                    if (last_found_reg) begin
                        status_next = ST_NO_MORE;
                    end else if (!q_cmd.has_zero && !q_cmd.has_one) begin
                        status_next  = ST_ABORT;
                        pos_next     = bit_cnt_reg;
                        bit_cnt_next = '0;
                    end else begin
                        if (q_cmd.has_zero && q_cmd.has_one && !take_one) begin
                            new_zb_next = {1'b0, bit_cnt_reg};
                        end
                        id_next[shift[IDW-1:0]] = take_one;
                        dir_next    = take_one ? ONE_MARK : ZERO_MARK;
                        chosen_next = take_one;
                        pos_next    = bit_cnt_reg;
                        if (bit_cnt_reg == LAST_POS) begin
                            done         = new_zb_next[6];
                            status_next  = ST_FOUND;
                            found_next   = 64'(id_next);
                            done_next    = done;
                            bit_cnt_next = '0;
                            if (done) begin
                                last_found_next = 1'b1;
                            end
                        end else begin
                            status_next  = ST_BIT_SENT;
                            bit_cnt_next = bit_cnt_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    m_valid_next = m_valid_reg && !m_ready;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_reg         <= '0;
            new_zb_reg     <= NONE_BRANCH;
            prior_zb_reg   <= NONE_BRANCH;
            bit_cnt_reg    <= '0;
            last_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            id_reg         <= id_next;
            new_zb_reg     <= new_zb_next;
            prior_zb_reg   <= prior_zb_next;
            bit_cnt_reg    <= bit_cnt_next;
            last_found_reg <= last_found_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        dir_reg    <= dir_next;
        chosen_reg <= chosen_next;
        pos_reg    <= pos_next;
        found_reg  <= found_next;
        done_reg   <= done_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = status_reg;
    assign m_direction_byte   = dir_reg;
    assign m_chosen_bit       = chosen_reg;
    assign m_bit_position     = pos_reg;
    assign m_found_id         = found_reg;
    assign m_enumeration_done = done_reg;

endmodule

// ===== design/binary_tree_id_search.sv =====
`timescale 1ns / 1ps
// Host-side search for a binary-tree device enumeration, one identifier bit per
// beat. Every command beat (restart, begin pass, bit response) is classified on
// entry and placed in a two-entry queue; the search stage resolves one beat per
// cycle against its identifier and branch registers and writes the answer into
// an output register, so the block sustains one beat per clock while the result
// side keeps up. A beat passes through the queue register and then the output
// register before its result is presented. Restart beats and beats with an
// unused kind code produce no result. The found identifier is reported on
// m_found_id, zero-extended from ID_BYTES*8 bits.
module binary_tree_id_search #(
    parameter int ID_BYTES = bts_pkg::ID_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_zero_reply,
    input  logic [7:0]  s_one_reply,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_direction_byte,
    output logic        m_chosen_bit,
    output logic [5:0]  m_bit_position,
    output logic [63:0] m_found_id,
    output logic        m_enumeration_done
);
    import bts_pkg::*;

    localparam logic [5:0] LAST_POS = 6'(ID_BYTES * 8 - 1);

    logic q_push;
    logic q_ready;
    cmd_t q_in_cmd;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    bts_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_zero_reply (s_zero_reply),
        .s_one_reply  (s_one_reply),
        .q_push       (q_push),
        .q_cmd        (q_in_cmd),
        .q_ready      (q_ready)
    );

    bts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_push),
        .in_cmd    (q_in_cmd),
        .in_ready  (q_ready),
        .out_valid (q_valid),
        .out_cmd   (q_cmd),
        .out_pop   (q_pop)
    );

    bts_back #(
        .ID_BYTES (ID_BYTES)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .q_cmd              (q_cmd),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_direction_byte   (m_direction_byte),
        .m_chosen_bit       (m_chosen_bit),
        .m_bit_position     (m_bit_position),
        .m_found_id         (m_found_id),
        .m_enumeration_done (m_enumeration_done)
    );

    a_found_at_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FOUND) |-> (m_bit_position == LAST_POS))
        else $error("device found reported before last bit position");

    a_id_only_on_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_FOUND) |-> (m_found_id == '0 && !m_enumeration_done))
        else $error("identifier or done flag outside device found beat");

    a_dir_matches_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_BIT_SENT || m_status == ST_FOUND)) |->
        (m_direction_byte == (m_chosen_bit ? ONE_MARK : ZERO_MARK)))
        else $error("direction byte disagrees with chosen bit");

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule
